@@ design/rsi_pkg.sv @@
`default_nettype none
// ============================================================================
// rsi_pkg - shared types and constants of the radix string parser
// Character codes, field widths, register indexes and the classified item
// that travels from the front end to the back end.
// ============================================================================
package rsi_pkg;

   localparam int unsigned SYM_SLOTS  = 16;  // symbol bytes held by the two table registers
   localparam int unsigned SYM_LEN_W  = 5;   // holds a symbol count of 0..16
   localparam int unsigned SYM_IDX_W  = 4;   // indexes one of 16 symbols
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS      = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;

   // One classified character, as seen against the base in force when it was taken.
   typedef struct packed {
      logic                 is_term;
      logic                 is_space;
      logic                 is_plus;
      logic                 is_minus;
      logic                 is_hit;
      logic [SYM_IDX_W-1:0] index;
      logic [SYM_LEN_W-1:0] radix;
      logic                 base_ok;
   } rsi_item_type;

   function automatic logic rsi_is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage
`default_nettype wire

@@ design/rsi_queue.sv @@
`default_nettype none
// ============================================================================
// rsi_queue - small register queue
// First-in first-out store with full and empty flags; the oldest entry is
// shown on the read port while the queue holds anything.
// ============================================================================
module rsi_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

@@ design/rsi_front.sv @@
`default_nettype none
// ============================================================================
// rsi_front - configuration registers and character classifier
// Holds the symbol table, derives the effective radix and base validity,
// and tags each accepted character for the back end.
// ============================================================================
module rsi_front import rsi_pkg::*; #(
   parameter int unsigned MAX_SYMBOLS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [CHAR_W-1:0]     char_code,
   output logic                       item_push,
   output rsi_item_type               item,
   input  wire logic                  queue_full
);

   localparam logic [SYM_LEN_W-1:0] LEN_CAP = SYM_LEN_W'(MAX_SYMBOLS);
   localparam logic [SYM_LEN_W-1:0] LEN_MIN = SYM_LEN_W'(2);

   logic [CSR_DATA_W-1:0] symbols_low_ff, symbols_high_ff;
   logic [SYM_LEN_W-1:0]  symbol_count_ff;
   logic                  cfg_wait_ff;
   logic [SYM_LEN_W-1:0]  base_len_ff, base_len_in;
   logic                  base_ok_ff,  base_ok_in;

   logic [2*CSR_DATA_W-1:0] sym_word;
   logic [CHAR_W-1:0]       sym [SYM_SLOTS];
   logic [SYM_LEN_W-1:0]    len_cap;
   logic                    csr_write;
   logic                    hit;
   logic [SYM_IDX_W-1:0]    hit_index;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         symbol_count_ff <= '0;
         cfg_wait_ff     <= 1'b0;
         base_len_ff     <= '0;
         base_ok_ff      <= 1'b0;
      end else begin
         cfg_wait_ff <= csr_write;
         base_len_ff <= base_len_in;
         base_ok_ff  <= base_ok_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_wdata;
               CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_wdata;
               CSR_SYMBOL_COUNT: symbol_count_ff <= csr_wdata[SYM_LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign sym_word = {symbols_high_ff, symbols_low_ff};

   always_comb begin
      for (int k = 0; k < SYM_SLOTS; k++) begin
         sym[k] = sym_word[k*CHAR_W +: CHAR_W];
      end
   end

   // Effective length: count saturated at the cap, cut at the first zero byte.
   assign len_cap = (symbol_count_ff > LEN_CAP) ? LEN_CAP : symbol_count_ff;

   always_comb begin
      base_len_in = len_cap;
      for (int k = SYM_SLOTS - 1; k >= 0; k--) begin
         if ((SYM_LEN_W'(k) < len_cap) && (sym[k] == CHAR_NUL)) begin
            base_len_in = SYM_LEN_W'(k);
         end
      end
   end

   always_comb begin
      base_ok_in = (base_len_in >= LEN_MIN);
      for (int i = 0; i < SYM_SLOTS; i++) begin
         if (SYM_LEN_W'(i) < base_len_in) begin
            if (rsi_is_space(sym[i]) || (sym[i] == CHAR_PLUS) || (sym[i] == CHAR_MINUS)) begin
               base_ok_in = 1'b0;
            end
            for (int j = i + 1; j < SYM_SLOTS; j++) begin
               if ((SYM_LEN_W'(j) < base_len_in) && (sym[j] == sym[i])) begin
                  base_ok_in = 1'b0;
               end
            end
         end
      end
   end

   // First matching symbol wins.
   always_comb begin
      hit       = 1'b0;
      hit_index = '0;
      for (int k = SYM_SLOTS - 1; k >= 0; k--) begin
         if ((SYM_LEN_W'(k) < base_len_ff) && (sym[k] == char_code)) begin
            hit       = 1'b1;
            hit_index = SYM_IDX_W'(k);
         end
      end
   end

   // Hold the input off for one cycle after a write while the base settles.
   assign full      = queue_full | cfg_wait_ff;
   assign item_push = push & ~full;

   always_comb begin
      item.is_term  = (char_code == CHAR_NUL);
      item.is_space = rsi_is_space(char_code);
      item.is_plus  = (char_code == CHAR_PLUS);
      item.is_minus = (char_code == CHAR_MINUS);
      item.is_hit   = hit;
      item.index    = hit_index;
      item.radix    = base_len_ff;
      item.base_ok  = base_ok_ff;
   end

endmodule
`default_nettype wire

@@ design/rsi_back.sv @@
`default_nettype none
// ============================================================================
// rsi_back - parse sequencer and accumulator
// Walks the whitespace, sign and digit phases, accumulates digits and
// forms the signed result at the terminator.
// ============================================================================
module rsi_back import rsi_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   input  wire rsi_item_type  item,
   output logic               item_pop,
   input  wire logic          result_full,
   output logic               result_push,
   output logic [VALUE_W-1:0] result_value
);

   localparam logic [1:0] PH_SPACE = 2'd0;
   localparam logic [1:0] PH_SIGN  = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   logic [1:0]                   phase_ff, phase_in;
   logic                         negative_ff, negative_in;
   logic [VALUE_W-1:0]           acc_ff, acc_in;
   logic [VALUE_W+SYM_LEN_W-1:0] product;
   logic [VALUE_W-1:0]           digit_sum;
   logic [VALUE_W-1:0]           signed_acc;

   assign item_pop    = item_valid & ~result_full;
   assign result_push = item_pop & item.is_term;

   assign product   = {{SYM_LEN_W{1'b0}}, acc_ff} * {{VALUE_W{1'b0}}, item.radix};
   assign digit_sum = product[VALUE_W-1:0] + {{(VALUE_W-SYM_IDX_W){1'b0}}, item.index};

   assign signed_acc   = negative_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign result_value = item.base_ok ? signed_acc : '0;

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      if (item_pop) begin
         priority if (item.is_term) begin
            phase_in    = PH_SPACE;
            negative_in = 1'b0;
            acc_in      = '0;
         end else if (phase_ff == PH_DONE) begin
            phase_in = PH_DONE;
         end else if ((phase_ff == PH_SPACE) && item.is_space) begin
            phase_in = PH_SPACE;
         end else if ((phase_ff != PH_DIGIT) && (item.is_plus || item.is_minus)) begin
            negative_in = negative_ff ^ item.is_minus;
            phase_in    = PH_SIGN;
         end else if (item.is_hit) begin
            acc_in   = digit_sum;
            phase_in = PH_DIGIT;
         end else begin
            phase_in = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SPACE;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
      end
   end

endmodule
`default_nettype wire

@@ design/radix_string_to_integer.sv @@
`default_nettype none
// ============================================================================
// radix_string_to_integer - arbitrary radix string to integer parser
// Streams characters in, parses a signed integer against a configured
// symbol table and queues one result per terminating zero character.
// ============================================================================
//
//   channel   ports                               transfer when
//   -------   ---------------------------------   --------------------
//   input     push, full, req_char_code           push && !full
//   result    pop, empty, rsp_parsed_value        pop && !empty
//   config    csr_valid, csr_ready, csr_index,    csr_valid && csr_ready
//             csr_wdata
//
// One character per cycle, sustained while full stays low. A character is
// classified, written into the item queue and popped from it by the
// accumulator; a terminator's value enters the result queue as it is
// retired. The accumulator step (one 32 x 5 multiply and add) sets the cycle.
// Reset clears the symbol table, the parse state and both queues. full
// rises when the item queue fills (result queue backed up) and for one
// cycle after every configuration write while the base is re-derived.
//
module radix_string_to_integer import rsi_pkg::*; #(
   parameter int unsigned MAX_SYMBOLS  = 16,
   parameter int unsigned QUEUE_DEPTH  = 2,
   parameter int unsigned RESULT_DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // characters in
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [CHAR_W-1:0]     req_char_code,
   // results out
   input  wire logic                  pop,
   output logic                       empty,
   output logic signed [VALUE_W-1:0]  rsp_parsed_value
);

   rsi_item_type       front_item;
   rsi_item_type       back_item;
   logic               front_push;
   logic               item_full;
   logic               item_empty;
   logic               back_pop;
   logic               result_full;
   logic               result_push;
   logic [VALUE_W-1:0] result_value;
   logic [VALUE_W-1:0] result_head;

   // Front end: register file, base analysis, classify each character.
   rsi_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .full       (full),
      .char_code  (req_char_code),
      .item_push  (front_push),
      .item       (front_item),
      .queue_full (item_full)
   );

   // Item queue decouples classification from the accumulator.
   rsi_queue #(
      .WIDTH ($bits(rsi_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_item),
      .full    (item_full),
      .rd_en   (back_pop),
      .rd_data (back_item),
      .empty   (item_empty)
   );

   // Back end: phase sequencing, sign and accumulation; stall only on a full
   // result queue.
   rsi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (~item_empty),
      .item         (back_item),
      .item_pop     (back_pop),
      .result_full  (result_full),
      .result_push  (result_push),
      .result_value (result_value)
   );

   // Result queue holds finished values until the consumer pops them.
   rsi_queue #(
      .WIDTH (VALUE_W),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (result_push),
      .wr_data (result_value),
      .full    (result_full),
      .rd_en   (pop),
      .rd_data (result_head),
      .empty   (empty)
   );

   assign rsp_parsed_value = $signed(result_head);

endmodule
`default_nettype wire
